@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the descriptor ring rtl
// the enclosing module supplies clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ABDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("abdr assertion failed");
`define ABDR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("abdr assertion failed");
`else
`define ABDR_ASSERT(lbl, prop)
`define ABDR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/core/abdr_pkg.sv @@
// types, codes and helper functions of the audio block descriptor ring
// used by every module of the block, no dependencies
package abdr_pkg;

  localparam int SLOTS = 16;
  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam int NumReports = 9;
  localparam int RepW  = $clog2(NumReports);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [RepW-1:0] rep_idx_t;

  // function codes
  localparam logic [2:0] FUNC_PUSH    = 3'd0;
  localparam logic [2:0] FUNC_PEEK    = 3'd1;
  localparam logic [2:0] FUNC_CONSUME = 3'd2;
  localparam logic [2:0] FUNC_CLOSE   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;
  localparam logic [2:0] FUNC_SNAP    = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CLOSED    = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_REFUSED   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_SLOTS     = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES = 2'd1;

  localparam logic [RepW-1:0] REP_LAST = RepW'(NumReports - 1);

  typedef struct packed {
    logic [2:0]  func;
    logic        block_ok;
    logic [15:0] frame_count;
    logic [20:0] byte_size;
    logic [8:0]  frame_bytes;
    logic [47:0] start_position;
    logic [31:0] buffer_tag;
    logic [31:0] render_tag;
    logic        end_flag;
    logic [15:0] take_frames;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        last;
    logic [3:0]  slot_index;
    logic [15:0] frames_left;
    logic [23:0] byte_offset;
    logic [23:0] bytes_left;
    logic [47:0] front_position;
    logic [8:0]  front_frame_bytes;
    logic [31:0] front_buffer_tag;
    logic [31:0] front_render_tag;
    logic        front_end;
    logic [31:0] report_value;
  } res_t;

  typedef struct packed {
    cnt_t        eff_slots;
    cnt_t        used;
    logic [20:0] max_bytes;
    logic [31:0] queued;
    logic [31:0] pushed;
    logic [31:0] retired;
    logic [31:0] full_rejects;
    logic [31:0] over_rejects;
    logic        closed;
  } snap_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [20:0] data;
  } cfg_wr_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v, logic [31:0] amt);
    logic [32:0] sum;
    sum = {1'b0, v} + {1'b0, amt};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic [23:0] sat24(logic [24:0] p);
    return p[24] ? 24'hFF_FFFF : p[23:0];
  endfunction

  // slots_in_use clamped to one .. SLOTS
  function automatic cnt_t eff_slots(logic [4:0] s);
    cnt_t e;
    if (s == 5'd0) begin
      e = cnt_t'(1);
    end else if (32'(s) > 32'(SLOTS)) begin
      e = cnt_t'(SLOTS);
    end else begin
      e = cnt_t'(s);
    end
    return e;
  endfunction

  function automatic idx_t advance(idx_t i, cnt_t e);
    cnt_t n;
    n = cnt_t'(i) + cnt_t'(1);
    return (n >= e) ? '0 : idx_t'(n);
  endfunction

endpackage

@@ rtl/core/audio_block_descriptor_ring_core.sv @@
// top level of the audio block descriptor ring: input register, ring control
// and result register; depends on abdr_pkg, abdr_ring_ctrl, abdr_out_stage
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid/s_axis_tready    tuser func, tdata descriptor
// m_axis    out        m_axis_tvalid/m_axis_tready    tuser status, tlast, tdata result
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// an item waits in the input register until it fires, then its result is
// registered in the result register. push, peek, consume, close and clear run
// at one item per cycle unless m_axis stalls or a snapshot drains; a snapshot
// holds the ring while the result register emits its nine reports. m_axis stalls
// back up through the result register into the input register. reset clears
// pointers and counters, sets config defaults; slot storage needs no clearing pass.
module audio_block_descriptor_ring_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // block_ok, frame_count, byte_size, frame_bytes, start_position,
  // buffer_tag, render_tag, end_flag, take_frames
  input  logic [175:0] s_axis_tdata,
  // func
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot_index, frames_left, byte_offset, bytes_left, front_position,
  // front_frame_bytes, front_buffer_tag, front_render_tag, front_end,
  // report_value, zero fill
  output logic [223:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [20:0]  cfg_data_i
);

  logic              in_vld_q, in_vld_d;
  abdr_pkg::item_t   item_q, item_d;
  logic              fire, s_acc;
  abdr_pkg::res_t    res, out_res;
  abdr_pkg::snap_t   snap;
  abdr_pkg::cfg_wr_t cfg_wr;

  assign cfg_ready_o   = 1'b1;
  assign cfg_wr.valid  = cfg_valid_i;
  assign cfg_wr.index  = cfg_index_i;
  assign cfg_wr.data   = cfg_data_i;

  assign s_axis_tready = !in_vld_q || fire;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.func           = s_axis_tuser;
    item_d.block_ok       = s_axis_tdata[0];
    item_d.frame_count    = s_axis_tdata[16:1];
    item_d.byte_size      = s_axis_tdata[37:17];
    item_d.frame_bytes    = s_axis_tdata[46:38];
    item_d.start_position = s_axis_tdata[94:47];
    item_d.buffer_tag     = s_axis_tdata[126:95];
    item_d.render_tag     = s_axis_tdata[158:127];
    item_d.end_flag       = s_axis_tdata[159];
    item_d.take_frames    = s_axis_tdata[175:160];
    in_vld_d = s_acc ? 1'b1 : (fire ? 1'b0 : in_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q <= item_d;
    end
  end

  abdr_ring_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .item_i (item_q),
    .fire_i (fire),
    .res_o  (res),
    .snap_o (snap)
  );

  abdr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (in_vld_q),
    .func_i      (item_q.func),
    .res_i       (res),
    .snap_i      (snap),
    .out_ready_i (m_axis_tready),
    .fire_o      (fire),
    .out_vld_o   (m_axis_tvalid),
    .out_o       (out_res)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tdata = {2'b00,
                         out_res.report_value,
                         out_res.front_end,
                         out_res.front_render_tag,
                         out_res.front_buffer_tag,
                         out_res.front_frame_bytes,
                         out_res.front_position,
                         out_res.bytes_left,
                         out_res.byte_offset,
                         out_res.frames_left,
                         out_res.slot_index};

endmodule

@@ rtl/core/abdr_ring_ctrl.sv @@
// ring pointers, counters, slot descriptor storage and per-item decision logic
// depends on abdr_pkg and assert_macros.svh
`include "assert_macros.svh"

module abdr_ring_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abdr_pkg::cfg_wr_t cfg_i,
  input  abdr_pkg::item_t   item_i,
  input  logic              fire_i,
  output abdr_pkg::res_t    res_o,
  output abdr_pkg::snap_t   snap_o
);

  logic [4:0]  slots_cfg_q;
  logic [20:0] max_bytes_q;

  abdr_pkg::idx_t head_q, head_d, tail_q, tail_d;
  abdr_pkg::cnt_t used_q, used_d, eff;
  logic           closed_q, closed_d;
  logic [31:0]    pushed_q, pushed_d, retired_q, retired_d;
  logic [31:0]    full_rej_q, full_rej_d, over_rej_q, over_rej_d;
  logic [31:0]    queued_q, queued_d;

  logic [15:0] slot_frames_q [abdr_pkg::SLOTS];
  logic [15:0] slot_done_q   [abdr_pkg::SLOTS];
  logic [8:0]  slot_fbytes_q [abdr_pkg::SLOTS];
  logic [47:0] slot_pos_q    [abdr_pkg::SLOTS];
  logic [31:0] slot_btag_q   [abdr_pkg::SLOTS];
  logic [31:0] slot_rtag_q   [abdr_pkg::SLOTS];
  logic        slot_end_q    [abdr_pkg::SLOTS];

  logic        push_we, cons_we;
  logic [15:0] h_frames, h_done, h_left, new_done;
  logic [8:0]  h_fb;
  logic [24:0] off_prod, left_prod;

  assign eff      = abdr_pkg::eff_slots(slots_cfg_q);
  assign h_frames = slot_frames_q[head_q];
  assign h_done   = slot_done_q[head_q];
  assign h_fb     = slot_fbytes_q[head_q];
  assign h_left   = h_frames - h_done;
  assign new_done = h_done + item_i.take_frames;
  assign off_prod  = 25'(h_done) * 25'(h_fb);
  assign left_prod = 25'(h_left) * 25'(h_fb);

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    used_d     = used_q;
    closed_d   = closed_q;
    pushed_d   = pushed_q;
    retired_d  = retired_q;
    full_rej_d = full_rej_q;
    over_rej_d = over_rej_q;
    queued_d   = queued_q;
    push_we    = 1'b0;
    cons_we    = 1'b0;
    res_o      = '0;
    res_o.last = 1'b1;
    unique case (item_i.func)
      abdr_pkg::FUNC_PUSH: begin
        if (closed_q) begin
          res_o.status = abdr_pkg::ST_CLOSED;
        end else if (!item_i.block_ok) begin
          res_o.status = abdr_pkg::ST_INVALID;
        end else if (item_i.byte_size > max_bytes_q) begin
          over_rej_d   = abdr_pkg::sat_inc(over_rej_q, 32'd1);
          res_o.status = abdr_pkg::ST_TOO_LARGE;
        end else if (used_q >= eff) begin
          full_rej_d   = abdr_pkg::sat_inc(full_rej_q, 32'd1);
          res_o.status = abdr_pkg::ST_FULL;
        end else begin
          push_we          = 1'b1;
          pushed_d         = abdr_pkg::sat_inc(pushed_q, 32'd1);
          queued_d         = abdr_pkg::sat_inc(queued_q, 32'(item_i.frame_count));
          tail_d           = abdr_pkg::advance(tail_q, eff);
          used_d           = used_q + abdr_pkg::cnt_t'(1);
          res_o.slot_index = 4'(tail_q);
        end
      end
      abdr_pkg::FUNC_PEEK: begin
        if (used_q == '0) begin
          res_o.status = abdr_pkg::ST_EMPTY;
        end else begin
          res_o.slot_index        = 4'(head_q);
          res_o.frames_left       = h_left;
          res_o.byte_offset       = abdr_pkg::sat24(off_prod);
          res_o.bytes_left        = abdr_pkg::sat24(left_prod);
          res_o.front_position    = slot_pos_q[head_q] + 48'(h_done);
          res_o.front_frame_bytes = h_fb;
          res_o.front_buffer_tag  = slot_btag_q[head_q];
          res_o.front_render_tag  = slot_rtag_q[head_q];
          res_o.front_end         = slot_end_q[head_q];
        end
      end
      abdr_pkg::FUNC_CONSUME: begin
        if (used_q == '0) begin
          res_o.status = abdr_pkg::ST_EMPTY;
        end else if (item_i.take_frames == 16'd0 || item_i.take_frames > h_left) begin
          res_o.status = abdr_pkg::ST_REFUSED;
        end else begin
          cons_we          = 1'b1;
          queued_d         = (32'(item_i.take_frames) > queued_q) ? 32'd0 :
                             queued_q - 32'(item_i.take_frames);
          res_o.slot_index = 4'(head_q);
          // front block exhausted: free its slot
          if (new_done == h_frames) begin
            retired_d = abdr_pkg::sat_inc(retired_q, 32'd1);
            head_d    = abdr_pkg::advance(head_q, eff);
            used_d    = used_q - abdr_pkg::cnt_t'(1);
          end
        end
      end
      abdr_pkg::FUNC_CLOSE: begin
        closed_d = 1'b1;
      end
      abdr_pkg::FUNC_CLEAR: begin
        head_d     = '0;
        tail_d     = '0;
        used_d     = '0;
        closed_d   = 1'b0;
        pushed_d   = '0;
        retired_d  = '0;
        full_rej_d = '0;
        over_rej_d = '0;
        queued_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_cfg_q <= 5'd16;
      max_bytes_q <= 21'd4096;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        abdr_pkg::REG_SLOTS:     slots_cfg_q <= cfg_i.data[4:0];
        abdr_pkg::REG_MAX_BYTES: max_bytes_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      used_q     <= '0;
      closed_q   <= 1'b0;
      pushed_q   <= '0;
      retired_q  <= '0;
      full_rej_q <= '0;
      over_rej_q <= '0;
      queued_q   <= '0;
    end else if (fire_i) begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      used_q     <= used_d;
      closed_q   <= closed_d;
      pushed_q   <= pushed_d;
      retired_q  <= retired_d;
      full_rej_q <= full_rej_d;
      over_rej_q <= over_rej_d;
      queued_q   <= queued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && push_we) begin
      slot_frames_q[tail_q] <= item_i.frame_count;
      slot_done_q[tail_q]   <= 16'd0;
      slot_fbytes_q[tail_q] <= item_i.frame_bytes;
      slot_pos_q[tail_q]    <= item_i.start_position;
      slot_btag_q[tail_q]   <= item_i.buffer_tag;
      slot_rtag_q[tail_q]   <= item_i.render_tag;
      slot_end_q[tail_q]    <= item_i.end_flag;
    end else if (fire_i && cons_we) begin
      slot_done_q[head_q] <= new_done;
    end
  end

  always_comb begin
    snap_o.eff_slots    = eff;
    snap_o.used         = (used_q > eff) ? eff : used_q;
    snap_o.max_bytes    = max_bytes_q;
    snap_o.queued       = queued_q;
    snap_o.pushed       = pushed_q;
    snap_o.retired      = retired_q;
    snap_o.full_rejects = full_rej_q;
    snap_o.over_rejects = over_rej_q;
    snap_o.closed       = closed_q;
  end

  `ABDR_ASSERT(a_used_bound, used_q <= abdr_pkg::cnt_t'(abdr_pkg::SLOTS))
  `ABDR_ASSERT_NEXT(a_closed_push_keeps_ring, fire_i && item_i.func == abdr_pkg::FUNC_PUSH && closed_q, $stable(used_q) && $stable(tail_q))

endmodule

@@ rtl/core/abdr_out_stage.sv @@
// result register and snapshot report sequencer
// depends on abdr_pkg and assert_macros.svh
`include "assert_macros.svh"

module abdr_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  input  logic [2:0]      func_i,
  input  abdr_pkg::res_t  res_i,
  input  abdr_pkg::snap_t snap_i,
  input  logic            out_ready_i,
  output logic            fire_o,
  output logic            out_vld_o,
  output abdr_pkg::res_t  out_o
);

  logic               out_vld_q, out_vld_d;
  abdr_pkg::res_t     out_q, out_d;
  logic               snap_act_q, snap_act_d;
  abdr_pkg::rep_idx_t snap_idx_q, snap_idx_d;
  logic               out_free;

  function automatic logic [31:0] report(abdr_pkg::snap_t s, abdr_pkg::rep_idx_t k);
    logic [31:0] v;
    unique case (k)
      abdr_pkg::RepW'(0): v = 32'(s.eff_slots);
      abdr_pkg::RepW'(1): v = 32'(s.used);
      abdr_pkg::RepW'(2): v = 32'(s.max_bytes);
      abdr_pkg::RepW'(3): v = s.queued;
      abdr_pkg::RepW'(4): v = s.pushed;
      abdr_pkg::RepW'(5): v = s.retired;
      abdr_pkg::RepW'(6): v = s.full_rejects;
      abdr_pkg::RepW'(7): v = s.over_rejects;
      abdr_pkg::RepW'(8): v = 32'(s.closed);
      default:            v = 32'd0;
    endcase
    return v;
  endfunction

  assign out_free = !out_vld_q || out_ready_i;
  // the ring holds still while snapshot reports drain
  assign fire_o   = in_vld_i && out_free && !snap_act_q;

  always_comb begin
    out_vld_d  = out_vld_q && !out_ready_i;
    out_d      = out_q;
    snap_act_d = snap_act_q;
    snap_idx_d = snap_idx_q;
    if (snap_act_q && out_free) begin
      out_vld_d          = 1'b1;
      out_d              = '0;
      out_d.report_value = report(snap_i, snap_idx_q);
      out_d.last         = (snap_idx_q == abdr_pkg::REP_LAST);
      if (snap_idx_q == abdr_pkg::REP_LAST) begin
        snap_act_d = 1'b0;
      end else begin
        snap_idx_d = snap_idx_q + abdr_pkg::rep_idx_t'(1);
      end
    end else if (fire_o) begin
      case (func_i) inside
        abdr_pkg::FUNC_SNAP: begin
          out_vld_d          = 1'b1;
          out_d              = '0;
          out_d.report_value = report(snap_i, '0);
          snap_act_d         = 1'b1;
          snap_idx_d         = abdr_pkg::rep_idx_t'(1);
        end
        abdr_pkg::FUNC_PUSH, abdr_pkg::FUNC_PEEK, abdr_pkg::FUNC_CONSUME,
        abdr_pkg::FUNC_CLOSE, abdr_pkg::FUNC_CLEAR: begin
          out_vld_d = 1'b1;
          out_d     = res_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      snap_act_q <= 1'b0;
      snap_idx_q <= '0;
    end else begin
      out_vld_q  <= out_vld_d;
      snap_act_q <= snap_act_d;
      snap_idx_q <= snap_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

  `ABDR_ASSERT(a_snap_shows_report, snap_act_q |-> out_vld_q && !out_q.last)
  `ABDR_ASSERT(a_snap_idx_nonzero, snap_act_q |-> snap_idx_q != '0)

endmodule
